/* rtl/core/lts_pkg.sv */
// ----------------------------------------------------------------------------
// Link test statistics package
// Shared widths, event codes and the structs passed between the
// statistics modules.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int SEQ_SPACE_DEFAULT = 256;

  // The sequence bitmap is stored as rows of sixteen bits.
  localparam int ROW_BITS  = 16;
  localparam int ROW_SEL_W = 4;

  localparam int SEQ_W      = 16;
  localparam int STRENGTH_W = 13;
  localparam int SUM_W      = 29;
  localparam int COUNT_W    = 16;
  localparam int DISTINCT_W = 9;
  localparam int EXPECTED_W = 10;

  localparam logic [EXPECTED_W-1:0] EXPECTED_RESET = 10'd200;

  typedef enum logic [1:0] {
    MODE_GOOD   = 2'd0,
    MODE_CRC    = 2'd1,
    MODE_REPORT = 2'd2
  } mode_t;

  // Bitmap update from the event stage.
  typedef struct packed {
    logic             mark;
    logic             clear;
    logic [SEQ_W-1:0] seq;
  } map_upd_t;

  // Event presented to the counter bank.
  typedef struct packed {
    logic                         good;
    logic                         crc;
    logic                         report;
    logic                         fresh;
    logic signed [STRENGTH_W-1:0] strength;
  } stat_ev_t;

  // Window summary handed to the result register.
  typedef struct packed {
    logic [COUNT_W-1:0]           received_count;
    logic [DISTINCT_W-1:0]        distinct_count;
    logic [EXPECTED_W-1:0]        lost_count;
    logic [COUNT_W-1:0]           crc_error_count;
    logic signed [SUM_W-1:0]      strength_sum;
    logic signed [STRENGTH_W-1:0] strength_min;
  } report_t;

endpackage

/* rtl/core/link_test_packet_statistics_unit.sv */
// ----------------------------------------------------------------------------
// Link test packet statistics unit
// Per-window receive statistics: good packets, distinct sequence numbers,
// losses against the expected count, CRC errors and signal strength.
//
//   channel  direction  handshake            payload
//   item     in         item_valid/stall     mode, seq_number, signal_strength
//   result   out        result_valid/stall   six window statistics
//   cfg      in         cfg_valid/cfg_ready  cfg_data (expected_count)
//
// One beat is taken per cycle while item_stall is low. A result passes
// through the event register and then the result register after its report
// beat is taken. Bitmap rows are read at intake and written from the event stage.
// Reset is synchronous and clears the window at once; the bitmap is
// invalidated through per-row valid flops, so no clearing pass is needed.
// A report beat waits while an earlier result is still stalled, which in
// turn stalls the item channel.
// ----------------------------------------------------------------------------
module link_test_packet_statistics_unit #(
  parameter int SEQ_SPACE = lts_pkg::SEQ_SPACE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          mode,
  input  logic [lts_pkg::SEQ_W-1:0]           seq_number,
  input  logic signed [lts_pkg::STRENGTH_W-1:0] signal_strength,

  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [lts_pkg::COUNT_W-1:0]         received_count,
  output logic [lts_pkg::DISTINCT_W-1:0]      distinct_count,
  output logic [lts_pkg::EXPECTED_W-1:0]      lost_count,
  output logic [lts_pkg::COUNT_W-1:0]         crc_error_count,
  output logic signed [lts_pkg::SUM_W-1:0]    strength_sum,
  output logic signed [lts_pkg::STRENGTH_W-1:0] strength_min,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lts_pkg::EXPECTED_W-1:0]      cfg_data
);
  import lts_pkg::*;

  logic                         item_accept;
  logic                         s1_valid;
  logic [1:0]                   s1_mode;
  logic [SEQ_W-1:0]             s1_seq;
  logic signed [STRENGTH_W-1:0] s1_strength;
  logic                         s1_advance;
  logic                         s1_fire;
  logic                         s1_report;
  logic                         fresh;
  logic [EXPECTED_W-1:0]        expected_count;
  map_upd_t                     map_upd;
  stat_ev_t                     stat_ev;
  report_t                      rpt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_count <= EXPECTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_count <= cfg_data;
    end
  end

  // Event stage. Only a report beat can be held here, and only while the
  // result register is full and stalled.
  assign s1_report   = s1_mode == MODE_REPORT;
  assign s1_advance  = !(s1_report && result_valid && result_stall);
  assign s1_fire     = s1_valid && s1_advance;
  assign item_stall  = s1_valid && !s1_advance;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_mode     <= mode;
      s1_seq      <= seq_number;
      s1_strength <= signal_strength;
    end
  end

  always_comb begin
    map_upd.mark  = s1_fire && (s1_mode == MODE_GOOD);
    map_upd.clear = s1_fire && s1_report;
    map_upd.seq   = s1_seq;
  end

  lts_seen_map #(
    .SEQ_SPACE(SEQ_SPACE)
  ) u_seen_map (
    .clk   (clk),
    .rst   (rst),
    .rd_en (item_accept),
    .rd_seq(seq_number),
    .upd   (map_upd),
    .fresh (fresh)
  );

  always_comb begin
    stat_ev.good     = map_upd.mark;
    stat_ev.crc      = s1_fire && (s1_mode == MODE_CRC);
    stat_ev.report   = map_upd.clear;
    stat_ev.fresh    = fresh;
    stat_ev.strength = s1_strength;
  end

  lts_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .ev            (stat_ev),
    .expected_count(expected_count),
    .rpt           (rpt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (map_upd.clear) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_upd.clear) begin
      received_count  <= rpt.received_count;
      distinct_count  <= rpt.distinct_count;
      lost_count      <= rpt.lost_count;
      crc_error_count <= rpt.crc_error_count;
      strength_sum    <= rpt.strength_sum;
      strength_min    <= rpt.strength_min;
    end
  end

`ifndef ASSERT_OFF
  a_report_held_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_report && result_valid && result_stall) |-> item_stall)
    else $error("report beat blocked but item channel not stalled");

  a_report_makes_result: assert property (@(posedge clk) disable iff (rst)
    map_upd.clear |=> result_valid)
    else $error("report beat did not produce a result");

  a_distinct_le_received: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (COUNT_W'(distinct_count) <= received_count))
    else $error("distinct count exceeds received count");

  a_empty_window_zero_strength: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (received_count == '0)) |-> ((strength_min == '0) && (strength_sum == '0)))
    else $error("empty window reports nonzero strength");
`endif

endmodule

/* rtl/core/lts_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lts_seen_map.sv */
// ----------------------------------------------------------------------------
// Sequence number bitmap
// Rows of the bitmap live in a RAM; one valid flop per row lets the whole
// map be cleared at once. The row is read when a beat is taken and
// updated from the event stage, with a bypass for back-to-back hits on a row.
// ----------------------------------------------------------------------------
module lts_seen_map #(
  parameter int SEQ_SPACE = lts_pkg::SEQ_SPACE_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [lts_pkg::SEQ_W-1:0] rd_seq,
  input  lts_pkg::map_upd_t        upd,
  output logic                     fresh
);
  import lts_pkg::*;

  localparam int ROWS   = (SEQ_SPACE + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] rd_data;
  logic [ROW_BITS-1:0] row_cur;
  logic [ROW_BITS-1:0] row_new;
  logic [ROW_AW-1:0]   rd_row;
  logic [ROW_AW-1:0]   upd_row;
  logic [ROW_AW-1:0]   fwd_row;
  logic [ROW_BITS-1:0] fwd_data;
  logic                fwd_valid;
  logic                upd_in_range;
  logic                wr_en;

  assign rd_row       = rd_seq[ROW_AW+ROW_SEL_W-1:ROW_SEL_W];
  assign upd_row      = upd.seq[ROW_AW+ROW_SEL_W-1:ROW_SEL_W];
  assign upd_in_range = upd.seq < SEQ_W'(SEQ_SPACE);

  // The row written on the previous edge was not yet visible to the read
  // that happened on that same edge, so it is taken from the bypass.
  always_comb begin
    if (!upd_in_range || !row_valid[upd_row]) begin
      row_cur = '0;
    end else if (fwd_valid && (fwd_row == upd_row)) begin
      row_cur = fwd_data;
    end else begin
      row_cur = rd_data;
    end
  end

  assign fresh   = upd_in_range && !row_cur[upd.seq[ROW_SEL_W-1:0]];
  assign wr_en   = upd.mark && fresh;
  assign row_new = row_cur | (ROW_BITS'(1) << upd.seq[ROW_SEL_W-1:0]);

  lts_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS),
    .ADDR_W(ROW_AW)
  ) u_rows (
    .clk  (clk),
    .we   (wr_en),
    .waddr(upd_row),
    .wdata(row_new),
    .re   (rd_en),
    .raddr(rd_row),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[upd_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_row  <= upd_row;
      fwd_data <= row_new;
    end
  end

endmodule

/* rtl/core/lts_stats.sv */
// ----------------------------------------------------------------------------
// Window counter bank
// Saturating packet, distinct and CRC counters, strength sum and minimum,
// and the window summary built from them.
// ----------------------------------------------------------------------------
module lts_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  lts_pkg::stat_ev_t             ev,
  input  logic [lts_pkg::EXPECTED_W-1:0] expected_count,
  output lts_pkg::report_t              rpt
);
  import lts_pkg::*;

  logic [COUNT_W-1:0]           good_packets;
  logic [DISTINCT_W-1:0]        distinct_seen;
  logic [COUNT_W-1:0]           crc_failures;
  logic signed [SUM_W-1:0]      strength_total;
  logic signed [STRENGTH_W-1:0] weakest_strength;

  logic signed [SUM_W:0]        sum_wide;
  logic signed [SUM_W-1:0]      strength_total_next;
  logic signed [STRENGTH_W-1:0] weakest_strength_next;
  logic [EXPECTED_W-1:0]        distinct_ext;

  assign sum_wide = {strength_total[SUM_W-1], strength_total}
                  + {{(SUM_W+1-STRENGTH_W){ev.strength[STRENGTH_W-1]}}, ev.strength};

  // The two top bits disagree only on overflow; the top bit gives the side.
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      strength_total_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      strength_total_next = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    if ((good_packets == '0) || (ev.strength < weakest_strength)) begin
      weakest_strength_next = ev.strength;
    end else begin
      weakest_strength_next = weakest_strength;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ev.report) begin
      good_packets     <= '0;
      distinct_seen    <= '0;
      crc_failures     <= '0;
      strength_total   <= '0;
      weakest_strength <= '0;
    end else if (ev.good) begin
      if (good_packets != '1) begin
        good_packets <= good_packets + 1'b1;
      end
      if (ev.fresh && (distinct_seen != '1)) begin
        distinct_seen <= distinct_seen + 1'b1;
      end
      strength_total   <= strength_total_next;
      weakest_strength <= weakest_strength_next;
    end else if (ev.crc) begin
      if (crc_failures != '1) begin
        crc_failures <= crc_failures + 1'b1;
      end
    end
  end

  assign distinct_ext = EXPECTED_W'(distinct_seen);

  always_comb begin
    rpt.received_count  = good_packets;
    rpt.distinct_count  = distinct_seen;
    rpt.lost_count      = (expected_count > distinct_ext) ? expected_count - distinct_ext
                                                          : '0;
    rpt.crc_error_count = crc_failures;
    rpt.strength_sum    = strength_total;
    rpt.strength_min    = weakest_strength;
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Link test packet statistics unit testbench
// Drives good-packet, CRC-error, unused and report beats into the block and
// compares every window report with a local model of the window counters or
// a report given in the table. A short table of directed beats covers the
// field extremes, empty windows and a bitmap filled twice over. Random windows
// follow under several expected_count settings, with gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lts_pkg::*;

  localparam int SEQ_SPACE     = SEQ_SPACE_DEFAULT;
  localparam int SUM_HI        = (1 << (SUM_W - 1)) - 1;
  localparam int SUM_LO        = -(1 << (SUM_W - 1));
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int DISTINCT_MAX  = (1 << DISTINCT_W) - 1;
  localparam int EXPECTED_MAX  = (1 << EXPECTED_W) - 1;
  localparam int PHASE_ITEMS   = 180;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  logic [1:0]                   mode;
  logic [SEQ_W-1:0]             seq_number;
  logic signed [STRENGTH_W-1:0] signal_strength;
  logic                         result_valid;
  logic                         result_stall;
  logic [COUNT_W-1:0]           received_count;
  logic [DISTINCT_W-1:0]        distinct_count;
  logic [EXPECTED_W-1:0]        lost_count;
  logic [COUNT_W-1:0]           crc_error_count;
  logic signed [SUM_W-1:0]      strength_sum;
  logic signed [STRENGTH_W-1:0] strength_min;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [EXPECTED_W-1:0]        cfg_data;

  link_test_packet_statistics_unit #(
    .SEQ_SPACE(SEQ_SPACE)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .seq_number      (seq_number),
    .signal_strength (signal_strength),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .received_count  (received_count),
    .distinct_count  (distinct_count),
    .lost_count      (lost_count),
    .crc_error_count (crc_error_count),
    .strength_sum    (strength_sum),
    .strength_min    (strength_min),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Window state of the local model.
  bit                           win_seen [SEQ_SPACE];
  logic [COUNT_W-1:0]           win_good;
  logic [DISTINCT_W-1:0]        win_distinct;
  logic [COUNT_W-1:0]           win_crc;
  logic signed [SUM_W-1:0]      win_sum;
  logic signed [STRENGTH_W-1:0] win_min;
  logic [EXPECTED_W-1:0]        exp_packets;

  report_t pending_reports [$];
  report_t head_report;
  int      mismatches;
  bit      no_idle;
  int      cfg_plan [$];

  typedef struct {
    logic [1:0]                   op;
    logic [SEQ_W-1:0]             seq;
    logic [SEQ_W-1:0]             seq_step;
    logic signed [STRENGTH_W-1:0] strength;
    int                           count;
    bit                           typed;
    report_t                      want;
  } stim_row_t;

  stim_row_t event_table [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic report_t window_report(input int rc, input int dc, input int lc,
                                            input int cc, input int ss, input int sm);
    report_t rep;
    rep.received_count  = rc[COUNT_W-1:0];
    rep.distinct_count  = dc[DISTINCT_W-1:0];
    rep.lost_count      = lc[EXPECTED_W-1:0];
    rep.crc_error_count = cc[COUNT_W-1:0];
    rep.strength_sum    = ss[SUM_W-1:0];
    rep.strength_min    = sm[STRENGTH_W-1:0];
    return rep;
  endfunction

  task automatic clear_window();
    foreach (win_seen[i]) win_seen[i] = 1'b0;
    win_good     = '0;
    win_distinct = '0;
    win_crc      = '0;
    win_sum      = '0;
    win_min      = '0;
  endtask

  task automatic update_window_stats(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
                                     input logic signed [STRENGTH_W-1:0] strength,
                                     output bit reported, output report_t rep);
    int total;
    reported = 1'b0;
    rep      = '0;
    case (op)
      MODE_GOOD: begin
        // The first packet of a window sets the minimum whatever its value.
        if (win_good == 0 || strength < win_min) win_min = strength;
        total = win_sum + strength;
        if (total > SUM_HI) total = SUM_HI;
        if (total < SUM_LO) total = SUM_LO;
        win_sum = total[SUM_W-1:0];
        if (seq < SEQ_SPACE && !win_seen[seq]) begin
          win_seen[seq] = 1'b1;
          if (win_distinct != DISTINCT_MAX) win_distinct++;
        end
        if (win_good != COUNT_MAX) win_good++;
      end
      MODE_CRC: begin
        if (win_crc != COUNT_MAX) win_crc++;
      end
      MODE_REPORT: begin
        reported            = 1'b1;
        rep.received_count  = win_good;
        rep.distinct_count  = win_distinct;
        rep.lost_count      = (exp_packets > win_distinct) ? exp_packets - win_distinct : '0;
        rep.crc_error_count = win_crc;
        rep.strength_sum    = win_sum;
        rep.strength_min    = win_min;
        clear_window();
      end
      default: begin
      end
    endcase
  endtask

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high so back-to-back beats need no gap.
  task automatic send_event(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
                            input logic signed [STRENGTH_W-1:0] strength,
                            input bit typed, input report_t want);
    int      gap;
    bit      reported;
    report_t rep;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid      <= 1'b1;
    mode            <= op;
    seq_number      <= seq;
    signal_strength <= strength;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    update_window_stats(op, seq, strength, reported, rep);
    if (reported) pending_reports.push_back(typed ? want : rep);
    @(negedge clk);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    item_valid <= 1'b0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      mismatches += pending_reports.size();
      $display("%0t: %0d window reports expected but never delivered",
               $time, pending_reports.size());
      pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_expected(input logic [EXPECTED_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    exp_packets = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] op, input int seq, input int seq_step,
                         input int strength, input int count, input bit typed,
                         input report_t want);
    stim_row_t row;
    row.op       = op;
    row.seq      = seq[SEQ_W-1:0];
    row.seq_step = seq_step[SEQ_W-1:0];
    row.strength = strength[STRENGTH_W-1:0];
    row.count    = count;
    row.typed    = typed;
    row.want     = want;
    event_table.push_back(row);
  endtask

  // Well-formed windows with random content, sprinkled with unused beats and
  // early reports; every window is closed by a report.
  task automatic run_random_windows(input int target);
    int                           sent;
    int                           len;
    int                           r;
    bit                           narrow;
    logic [1:0]                   op;
    logic [SEQ_W-1:0]             seq;
    logic signed [STRENGTH_W-1:0] strength;
    sent = 0;
    while (sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      narrow  = ($urandom_range(0, 2) == 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 320) : $urandom_range(0, 40);
      for (int k = 0; k < len; k++) begin
        r        = $urandom_range(0, 99);
        seq      = SEQ_W'($urandom());
        strength = STRENGTH_W'($urandom());
        if (r < 72) begin
          op = MODE_GOOD;
          if (r < 50) seq = SEQ_W'(narrow ? $urandom_range(0, 15)
                                          : $urandom_range(0, SEQ_SPACE - 1));
          if ($urandom_range(0, 4) != 0) strength = STRENGTH_W'(0 - int'($urandom_range(0, 2560)));
        end else if (r < 88) begin
          op = MODE_CRC;
        end else if (r < 95) begin
          op = MODE_UNUSED;
        end else begin
          op = MODE_REPORT;
        end
        send_event(op, seq, strength, 1'b0, '0);
        if (op != MODE_UNUSED) sent++;
      end
      seq      = SEQ_W'($urandom());
      strength = STRENGTH_W'($urandom());
      send_event(MODE_REPORT, seq, strength, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic check_stat(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report beat with none expected: received %0d distinct %0d lost %0d",
                 $time, received_count, distinct_count, lost_count);
      end else begin
        head_report = pending_reports.pop_front();
        check_stat("received_count", head_report.received_count, received_count);
        check_stat("distinct_count", head_report.distinct_count, distinct_count);
        check_stat("lost_count", head_report.lost_count, lost_count);
        check_stat("crc_error_count", head_report.crc_error_count, crc_error_count);
        check_stat("strength_sum", head_report.strength_sum, strength_sum);
        check_stat("strength_min", head_report.strength_min, strength_min);
      end
    end
  end

  // Receiver back-pressure: open stretches, some long, between random stalls.
  initial begin
    int run;
    result_stall = 1'b0;
    forever begin
      repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12)) @(negedge clk);
      run = idle_len();
      if (run > 0) begin
        result_stall <= 1'b1;
        repeat (run) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    mode            = MODE_GOOD;
    seq_number      = '0;
    signal_strength = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    mismatches      = 0;
    no_idle         = 1'b0;
    clear_window();
    exp_packets = EXPECTED_RESET;

    add_row(MODE_REPORT, 0, 0, 0, 1, 1'b1, window_report(0, 0, 200, 0, 0, 0));
    add_row(MODE_UNUSED, 65535, 0, -1, 1, 1'b0, '0);
    add_row(MODE_GOOD, 0, 0, -2560, 1, 1'b0, '0);
    add_row(MODE_GOOD, SEQ_SPACE - 1, 0, 0, 1, 1'b0, '0);
    add_row(MODE_GOOD, SEQ_SPACE - 1, 0, -100, 1, 1'b0, '0);
    add_row(MODE_GOOD, SEQ_SPACE, 0, -4096, 1, 1'b0, '0);
    add_row(MODE_GOOD, 65535, 0, 4095, 1, 1'b0, '0);
    add_row(MODE_CRC, 1234, 0, -7, 1, 1'b0, '0);
    add_row(MODE_UNUSED, 0, 0, 0, 1, 1'b0, '0);
    add_row(MODE_REPORT, 0, 0, 0, 1, 1'b0, '0);
    add_row(MODE_REPORT, 65535, 0, 4095, 1, 1'b0, '0);
    add_row(MODE_GOOD, 5, 0, 4095, 1, 1'b0, '0);
    add_row(MODE_GOOD, 6, 0, 4095, 1, 1'b0, '0);
    add_row(MODE_REPORT, 0, 0, 0, 1, 1'b0, '0);
    // Full bitmap, swept twice: distinct stops at the space and lost clamps.
    add_row(MODE_GOOD, 0, 1, -1, SEQ_SPACE, 1'b0, '0);
    add_row(MODE_GOOD, 0, 1, -1, SEQ_SPACE, 1'b0, '0);
    add_row(MODE_REPORT, 0, 0, 0, 1, 1'b1,
            window_report(2 * SEQ_SPACE, SEQ_SPACE, 0, 0, -2 * SEQ_SPACE, -1));

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (event_table[i]) begin
      no_idle = (event_table[i].count > 2 * SEQ_SPACE);
      for (int k = 0; k < event_table[i].count; k++) begin
        send_event(event_table[i].op,
                   SEQ_W'(event_table[i].seq + k * event_table[i].seq_step),
                   event_table[i].strength, event_table[i].typed, event_table[i].want);
      end
    end

    cfg_plan = '{0, EXPECTED_MAX, 1, SEQ_SPACE, SEQ_SPACE - 1};
    cfg_plan.push_back($urandom_range(0, EXPECTED_MAX));
    foreach (cfg_plan[i]) begin
      drain_results();
      write_expected(EXPECTED_W'(cfg_plan[i]));
      run_random_windows(PHASE_ITEMS);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
